// ----- rtl/deq_pkg.sv -----
// deq_pkg: shared types and constants for the double-ended queue
`timescale 1ns / 1ps
package deq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int OCC_W = 5;
   localparam int RSP_DATA_W = 40;

   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

// ----- rtl/deq_ctrl.sv -----
// deq_ctrl: state machine sequencing capture and execution of one operation
`timescale 1ns / 1ps
module deq_ctrl import deq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          rsp_tready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      dp_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // result register must be free or draining this cycle
            if (!dp_status.out_busy || rsp_tready) begin
               dp_cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/deq_datapath.sv -----
// deq_datapath: ring buffer, pointers, count and result register
`timescale 1ns / 1ps
module deq_datapath import deq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            dp_cmd,
   output dp_status_type         dp_status,
   input  logic [1:0]            req_op,
   input  logic [WORD_W-1:0]     req_word,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [WORD_W-1:0]     rsp_word,
   output logic [1:0]            rsp_status,
   output logic [OCC_W-1:0]      rsp_occ
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WORD_W-1:0] mem [DEPTH];

   op_type            op_ff;
   logic [WORD_W-1:0] word_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_sel_ff;
   status_type        status_ff, status_in;
   logic [OCC_W-1:0]  occ_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              full, empty;
   logic [IDX_W-1:0]  head_dec, head_inc, tail_dec, tail_inc;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // wrap at the last slot so any depth works
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      wr_en     = 1'b0;
      wr_addr   = head_dec;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               head_in  = head_dec;
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_REAR: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               tail_in  = tail_inc;
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_in  = head_inc;
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               count_in = count_ff - 1'b1;
            end
         end
         OP_POP_REAR: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               tail_in  = tail_dec;
               rd_en    = 1'b1;
               rd_addr  = tail_dec;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec && wr_en) begin
         mem[wr_addr] <= word_ff;
      end
      if (dp_cmd.exec && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff   <= op_type'(req_op);
         word_ff <= req_word;
      end
      if (dp_cmd.exec) begin
         mem_sel_ff <= rd_en;
         status_ff  <= status_in;
         occ_ff     <= OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.exec) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign dp_status.out_busy = valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_occ    = occ_ff;
   assign rsp_word   = mem_sel_ff ? rd_data_ff :
                       ((status_ff == STATUS_EMPTY) ? EMPTY_WORD : '0);

endmodule

// ----- rtl/double_ended_queue.sv -----
// double_ended_queue: top level of the ring-buffer double-ended queue
//
//  channel   dir  handshake               payload
//  req       in   req_tvalid/req_tready   tdata push_value, tuser op
//  rsp       out  rsp_tvalid/rsp_tready   tdata pop_value+occupancy, tuser status
//
// each operation is captured from the transfer in the idle state; the exec state then updates
// the pointers and accesses the single-port entry memory
// the result sits in an output register; the next request is captured while
// it waits, and execution holds until that register drains
// reset clears the pointers, count and result valid; entries are not cleared
`timescale 1ns / 1ps
module double_ended_queue import deq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,  // [31:0] push_value
   input  logic [1:0]            req_tuser,  // [1:0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] pop_value, [36:32] occupancy
   output logic [1:0]            rsp_tuser   // [1:0] status
);

   dp_cmd_type        dp_cmd;
   dp_status_type     dp_status;
   logic [WORD_W-1:0] rsp_word;
   logic [OCC_W-1:0]  rsp_occ;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   deq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .req_op     (req_tuser),
      .req_word   (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_word   (rsp_word),
      .rsp_status (rsp_tuser),
      .rsp_occ    (rsp_occ)
   );

   assign rsp_tdata = {{(RSP_DATA_W - WORD_W - OCC_W){1'b0}}, rsp_occ, rsp_word};

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// double_ended_queue_tb: self-checking testbench for the ring-buffer double-ended queue
`timescale 1ns / 1ps
module double_ended_queue_tb import deq_pkg::*; ;

   typedef struct packed {
      logic [WORD_W-1:0] pop_value;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } deque_result_type;

   // shadow copy of the queue contents, one expected response per request
   class deque_mirror;
      logic [WORD_W-1:0] slot_word [DEPTH];
      int                front_idx = 0;
      int                back_idx = 0;
      int                held = 0;
      int                errors = 0;
      deque_result_type  expected [$];

      function void note_request(op_type op, logic [WORD_W-1:0] word);
         deque_result_type want;
         want.pop_value = '0;
         want.status = STATUS_OK;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (held >= DEPTH) begin
                  want.status = STATUS_FULL;
               end else if (op == OP_PUSH_FRONT) begin
                  front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
                  slot_word[front_idx] = word;
                  held++;
               end else begin
                  slot_word[back_idx] = word;
                  back_idx = (back_idx + 1) % DEPTH;
                  held++;
               end
            end
            default: begin
               if (held == 0) begin
                  want.status = STATUS_EMPTY;
                  want.pop_value = EMPTY_WORD;
               end else if (op == OP_POP_FRONT) begin
                  want.pop_value = slot_word[front_idx];
                  front_idx = (front_idx + 1) % DEPTH;
                  held--;
               end else begin
                  back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
                  want.pop_value = slot_word[back_idx];
                  held--;
               end
            end
         endcase
         want.occupancy = OCC_W'(held);
         expected.push_back(want);
      endfunction

      function void check_response(logic [WORD_W-1:0] value, logic [1:0] status,
                                   logic [OCC_W-1:0] occupancy);
         deque_result_type want;
         if (expected.size() == 0) begin
            $error("response transfer with nothing outstanding: pop_value %0d status %0d",
                   $signed(value), status);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (value !== want.pop_value) begin
            $error("pop_value expected %0d actual %0d", $signed(want.pop_value),
                   $signed(value));
            errors++;
         end
         if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            errors++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy expected %0d actual %0d", want.occupancy, occupancy);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   deque_mirror mirror;
   int          burst_left = 0;
   int          stall_left = 0;
   int          rx_cycle = 0;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // receiver: free-running stretches, short stalls and long stalls in turn
   always @(negedge clock) begin
      rx_cycle++;
      if (stall_left == 0) begin
         case ((rx_cycle / 97) % 3)
            0: stall_left = 0;
            1: if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
            default: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
         endcase
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_response(rsp_tdata[WORD_W-1:0], rsp_tuser,
                               rsp_tdata[WORD_W +: OCC_W]);
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_op(op_type op, logic [WORD_W-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.note_request(op, word);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (mirror.expected.size() != 0) @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int push_pct;
      mirror = new;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_PUSH_FRONT;
      rsp_tready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pops at both ends, fill past full with wrap at the front, then pop at each end
      send_op(OP_POP_FRONT, 32'h7fff_ffff);
      send_op(OP_POP_REAR, 32'h8000_0000);
      send_op(OP_PUSH_FRONT, 32'h7fff_ffff);
      send_op(OP_PUSH_REAR, 32'h8000_0000);
      send_op(OP_PUSH_FRONT, '1);
      send_op(OP_PUSH_REAR, '0);
      for (int i = 0; i < DEPTH - 4; i++)
         send_op((i % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, $urandom());
      send_op(OP_PUSH_FRONT, 32'h1234_5678);
      send_op(OP_PUSH_REAR, 32'h8765_4321);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_POP_REAR, '1);
      wait_for_drain();

      push_pct = 50;
      for (int n = 0; n < 1300; n++) begin
         // vary the push/pop mix so occupancy sweeps between empty and full
         if (n % 60 == 0) begin
            case ($urandom_range(0, 4))
               0: push_pct = 90;
               1: push_pct = 75;
               2: push_pct = 50;
               3: push_pct = 25;
               default: push_pct = 10;
            endcase
         end
         if (n == 650) wait_for_drain();
         pace_sender();
         if ($urandom_range(1, 100) <= push_pct)
            send_op($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_word());
         else
            send_op($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, $urandom());
      end

      wait_for_drain();
      repeat (8) @(negedge clock);
      if (mirror.errors == 0 && mirror.expected.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
